@@ hw/rtl/rdds_pkg.sv @@
package rdds_pkg;

    localparam int POSITION_WIDTH = 32;
    localparam int RATE_WIDTH     = 21;

    localparam int REQ_WIDTH      = 2;
    localparam int VEL_WIDTH      = 16;
    localparam int VEL_FRAC_BITS  = 12;
    localparam int ACCEL_WIDTH    = 16;
    localparam int MAX_RATE_WIDTH = 20;
    localparam int PHASE_WIDTH    = 21;
    localparam int VSCALE_WIDTH   = 20;
    localparam int TIMEOUT_WIDTH  = 16;
    localparam int MS_WIDTH       = 16;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 21;

    localparam int MAG_WIDTH  = RATE_WIDTH - 1;
    localparam int PROD_WIDTH = VEL_WIDTH + VSCALE_WIDTH;
    localparam int RAMP_WIDTH =
        ((RATE_WIDTH > ACCEL_WIDTH) ? RATE_WIDTH : ACCEL_WIDTH + 1) + 1;
    localparam int SUM_WIDTH  =
        ((PHASE_WIDTH > MAG_WIDTH) ? PHASE_WIDTH : MAG_WIDTH) + 1;

    localparam logic [ACCEL_WIDTH-1:0]    ACCEL_RESET    = ACCEL_WIDTH'(1);
    localparam logic [MAX_RATE_WIDTH-1:0] MAX_RATE_RESET = MAX_RATE_WIDTH'(50000);
    localparam logic [PHASE_WIDTH-1:0]    MODULUS_RESET  = PHASE_WIDTH'(100000);
    localparam logic [VSCALE_WIDTH-1:0]   VSCALE_RESET   = VSCALE_WIDTH'(10000);
    localparam logic [TIMEOUT_WIDTH-1:0]  TIMEOUT_RESET  = TIMEOUT_WIDTH'(150);

    // largest magnitude the rate word holds
    localparam logic [PROD_WIDTH-1:0] RATE_LIMIT =
        PROD_WIDTH'((64'd1 << (RATE_WIDTH - 1)) - 64'd1);

    typedef logic signed [RATE_WIDTH-1:0] rate_t;

    typedef enum logic [REQ_WIDTH-1:0] {
        REQ_STEP_TICK = 2'd0,
        REQ_VELOCITY  = 2'd1,
        REQ_MS_TICK   = 2'd2,
        REQ_HALT      = 2'd3
    } req_type_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ACCEL_STEP     = 3'd0,
        CFG_MAX_RATE       = 3'd1,
        CFG_PHASE_MODULUS  = 3'd2,
        CFG_VELOCITY_SCALE = 3'd3,
        CFG_STALE_TIMEOUT  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        rate_t                  rate;
        logic [PHASE_WIDTH-1:0] phase;
        logic                   moving;
        logic                   fwd;
        logic                   pulse;
    } tick_res_t;

endpackage

@@ hw/rtl/rdds_scale.sv @@
module rdds_scale (
    input  logic signed [rdds_pkg::VEL_WIDTH-1:0]      velocity_cmd,
    input  logic        [rdds_pkg::VSCALE_WIDTH-1:0]   velocity_scale,
    input  logic        [rdds_pkg::MAX_RATE_WIDTH-1:0] max_rate,
    output rdds_pkg::rate_t                            target
);

    logic                                neg;
    logic [rdds_pkg::VEL_WIDTH-1:0]      vel_mag;
    logic [rdds_pkg::PROD_WIDTH-1:0]     prod;
    logic [rdds_pkg::PROD_WIDTH-1:0]     quot;
    logic [rdds_pkg::PROD_WIDTH-1:0]     lim;
    logic [rdds_pkg::PROD_WIDTH-1:0]     mag;
    rdds_pkg::rate_t                     mag_r;

    always_comb begin
        neg     = velocity_cmd[rdds_pkg::VEL_WIDTH-1];
        vel_mag = neg ? rdds_pkg::VEL_WIDTH'(-velocity_cmd)
                      : rdds_pkg::VEL_WIDTH'(velocity_cmd);
        prod    = rdds_pkg::PROD_WIDTH'(vel_mag) * rdds_pkg::PROD_WIDTH'(velocity_scale);
        // magnitude shift truncates toward zero
        quot    = prod >> rdds_pkg::VEL_FRAC_BITS;
        lim     = rdds_pkg::PROD_WIDTH'(max_rate);
        if (lim > rdds_pkg::RATE_LIMIT) begin
            lim = rdds_pkg::RATE_LIMIT;
        end
        mag     = (quot > lim) ? lim : quot;
        mag_r   = rdds_pkg::RATE_WIDTH'(mag);
        target  = neg ? -mag_r : mag_r;
    end

endmodule

@@ hw/rtl/rdds_tick.sv @@
module rdds_tick (
    input  rdds_pkg::rate_t                         cur_rate,
    input  rdds_pkg::rate_t                         tgt_rate,
    input  logic [rdds_pkg::PHASE_WIDTH-1:0]        phase,
    input  logic [rdds_pkg::ACCEL_WIDTH-1:0]        accel_step,
    input  logic [rdds_pkg::PHASE_WIDTH-1:0]        phase_modulus,
    output rdds_pkg::tick_res_t                     res
);

    logic signed [rdds_pkg::RAMP_WIDTH-1:0] cur_w;
    logic signed [rdds_pkg::RAMP_WIDTH-1:0] tgt_w;
    logic signed [rdds_pkg::RAMP_WIDTH-1:0] acc_w;
    logic signed [rdds_pkg::RAMP_WIDTH-1:0] up;
    logic signed [rdds_pkg::RAMP_WIDTH-1:0] dn;
    logic signed [rdds_pkg::RAMP_WIDTH-1:0] ramped;
    rdds_pkg::rate_t                        rate_new;
    logic [rdds_pkg::MAG_WIDTH-1:0]         mag;
    logic [rdds_pkg::PHASE_WIDTH-1:0]       modv;
    logic [rdds_pkg::SUM_WIDTH-1:0]         mod_w;
    logic [rdds_pkg::SUM_WIDTH-1:0]         sum;
    logic [rdds_pkg::SUM_WIDTH-1:0]         wrapped;
    logic [rdds_pkg::SUM_WIDTH-1:0]         sat;
    logic                                   ovf;

    always_comb begin
        cur_w = rdds_pkg::RAMP_WIDTH'(cur_rate);
        tgt_w = rdds_pkg::RAMP_WIDTH'(tgt_rate);
        acc_w = rdds_pkg::RAMP_WIDTH'(accel_step);
        up    = cur_w + acc_w;
        dn    = cur_w - acc_w;
        priority if (cur_w < tgt_w) begin
            ramped = (up > tgt_w) ? tgt_w : up;
        end else if (cur_w > tgt_w) begin
            ramped = (dn < tgt_w) ? tgt_w : dn;
        end else begin
            ramped = cur_w;
        end
        rate_new = rdds_pkg::RATE_WIDTH'(ramped);

        mag   = rate_new[rdds_pkg::RATE_WIDTH-1] ? rdds_pkg::MAG_WIDTH'(-rate_new)
                                                 : rdds_pkg::MAG_WIDTH'(rate_new);
        modv  = (phase_modulus == '0) ? rdds_pkg::PHASE_WIDTH'(1) : phase_modulus;
        mod_w = rdds_pkg::SUM_WIDTH'(modv);
        sum   = rdds_pkg::SUM_WIDTH'(phase) + rdds_pkg::SUM_WIDTH'(mag);
        ovf   = (sum >= mod_w);
        wrapped = ovf ? (sum - mod_w) : sum;
        // excess rate beyond one pulse per tick is dropped
        sat   = (wrapped >= mod_w) ? (mod_w - rdds_pkg::SUM_WIDTH'(1)) : wrapped;

        res.rate   = rate_new;
        res.moving = (rate_new != '0);
        res.fwd    = ~rate_new[rdds_pkg::RATE_WIDTH-1];
        res.phase  = rdds_pkg::PHASE_WIDTH'(sat);
        res.pulse  = res.moving & ovf;
    end

endmodule

@@ hw/rtl/ramped_dds_step_generator_unit.sv @@
// Ramped DDS step pulse generator.
// Request channel (s_*): valid/ready, one request per transfer: step tick,
// velocity command, millisecond tick or halt; velocity_cmd matters only for a
// velocity command. Result channel (m_*): valid/ready, exactly one result per
// request: step pulse flag, direction, position, current rate and a flag set
// when the staleness watchdog zeroed the target on that request.
// Configuration channel (cfg_*): always ready; index 0..4 selects accel step,
// max rate, phase modulus, velocity scale, stale timeout. Other indices are
// ignored. Write only while no request is in flight.
// Path: a request accepted into the input register then passes the state/result
// register, where its result becomes valid. Throughput is one request per cycle
// while results are taken; the ramp, phase add and wrap of a step tick, or the
// 16x20 multiply and clamp of a velocity command, are combinational.
// Reset (aresetn low, synchronous) clears rate, target, phase, position,
// direction (reverse) and the watchdog count, and restores register defaults.
// When the receiver stalls, the result holds and the input register fills;
// s_ready then drops until the result is taken. Nothing is dropped.
module ramped_dds_step_generator_unit (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_valid,
    output logic                                          s_ready,
    input  logic [rdds_pkg::REQ_WIDTH-1:0]                s_req_type,
    input  logic signed [rdds_pkg::VEL_WIDTH-1:0]         s_velocity_cmd,
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output logic                                          m_step_pulse,
    output logic                                          m_direction,
    output logic signed [rdds_pkg::POSITION_WIDTH-1:0]    m_position_out,
    output logic signed [rdds_pkg::RATE_WIDTH-1:0]        m_rate_out,
    output logic                                          m_stale_halt,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [rdds_pkg::CFG_INDEX_WIDTH-1:0]          cfg_index,
    input  logic [rdds_pkg::CFG_DATA_WIDTH-1:0]           cfg_data
);

    logic                                   in_valid_reg, in_valid_next;
    rdds_pkg::req_type_t                    in_req_reg, in_req_next;
    logic signed [rdds_pkg::VEL_WIDTH-1:0]  in_vel_reg, in_vel_next;

    logic                                   out_valid_reg, out_valid_next;
    logic                                   out_pulse_reg, out_pulse_next;
    logic                                   out_stale_reg, out_stale_next;

    rdds_pkg::rate_t                        cur_rate_reg, cur_rate_next;
    rdds_pkg::rate_t                        tgt_rate_reg, tgt_rate_next;
    logic [rdds_pkg::PHASE_WIDTH-1:0]       phase_reg, phase_next;
    logic [rdds_pkg::POSITION_WIDTH-1:0]    pos_reg, pos_next;
    logic                                   dir_reg, dir_next;
    logic [rdds_pkg::MS_WIDTH-1:0]          ms_cnt_reg, ms_cnt_next;

    logic [rdds_pkg::ACCEL_WIDTH-1:0]       accel_reg, accel_next;
    logic [rdds_pkg::MAX_RATE_WIDTH-1:0]    max_rate_reg, max_rate_next;
    logic [rdds_pkg::PHASE_WIDTH-1:0]       modulus_reg, modulus_next;
    logic [rdds_pkg::VSCALE_WIDTH-1:0]      vscale_reg, vscale_next;
    logic [rdds_pkg::TIMEOUT_WIDTH-1:0]     timeout_reg, timeout_next;

    logic                                   fire;
    logic [rdds_pkg::MS_WIDTH-1:0]          ms_inc;
    rdds_pkg::rate_t                        scaled;
    rdds_pkg::tick_res_t                    tick;

    rdds_scale u_scale (
        .velocity_cmd   (in_vel_reg),
        .velocity_scale (vscale_reg),
        .max_rate       (max_rate_reg),
        .target         (scaled)
    );

    rdds_tick u_tick (
        .cur_rate      (cur_rate_reg),
        .tgt_rate      (tgt_rate_reg),
        .phase         (phase_reg),
        .accel_step    (accel_reg),
        .phase_modulus (modulus_reg),
        .res           (tick)
    );

    assign fire      = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready   = ~in_valid_reg | fire;
    assign cfg_ready = 1'b1;

    assign m_valid        = out_valid_reg;
    assign m_step_pulse   = out_pulse_reg;
    assign m_stale_halt   = out_stale_reg;
    assign m_direction    = dir_reg;
    assign m_position_out = pos_reg;
    assign m_rate_out     = cur_rate_reg;

    always_comb begin
        in_valid_next = s_ready ? s_valid : in_valid_reg;
        in_req_next   = in_req_reg;
        in_vel_next   = in_vel_reg;
        if (s_valid && s_ready) begin
            in_req_next = rdds_pkg::req_type_t'(s_req_type);
            in_vel_next = s_velocity_cmd;
        end
    end

    always_comb begin
        accel_next    = accel_reg;
        max_rate_next = max_rate_reg;
        modulus_next  = modulus_reg;
        vscale_next   = vscale_reg;
        timeout_next  = timeout_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rdds_pkg::CFG_ACCEL_STEP: begin
                    accel_next = rdds_pkg::ACCEL_WIDTH'(cfg_data);
                end
                rdds_pkg::CFG_MAX_RATE: begin
                    max_rate_next = rdds_pkg::MAX_RATE_WIDTH'(cfg_data);
                end
                rdds_pkg::CFG_PHASE_MODULUS: begin
                    modulus_next = rdds_pkg::PHASE_WIDTH'(cfg_data);
                end
                rdds_pkg::CFG_VELOCITY_SCALE: begin
                    vscale_next = rdds_pkg::VSCALE_WIDTH'(cfg_data);
                end
                rdds_pkg::CFG_STALE_TIMEOUT: begin
                    timeout_next = rdds_pkg::TIMEOUT_WIDTH'(cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cur_rate_next  = cur_rate_reg;
        tgt_rate_next  = tgt_rate_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        dir_next       = dir_reg;
        ms_cnt_next    = ms_cnt_reg;
        out_pulse_next = out_pulse_reg;
        out_stale_next = out_stale_reg;
        out_valid_next = m_ready ? 1'b0 : out_valid_reg;
        ms_inc = (ms_cnt_reg == '1) ? ms_cnt_reg : ms_cnt_reg + rdds_pkg::MS_WIDTH'(1);

        if (fire) begin
            out_valid_next = 1'b1;
            out_pulse_next = 1'b0;
            out_stale_next = 1'b0;
            unique case (in_req_reg)
                rdds_pkg::REQ_STEP_TICK: begin
                    cur_rate_next = tick.rate;
                    if (tick.moving) begin
                        dir_next   = tick.fwd;
                        phase_next = tick.phase;
                    end
                    if (tick.pulse) begin
                        out_pulse_next = 1'b1;
                        pos_next = tick.fwd ? pos_reg + rdds_pkg::POSITION_WIDTH'(1)
                                            : pos_reg - rdds_pkg::POSITION_WIDTH'(1);
                    end
                end
                rdds_pkg::REQ_VELOCITY: begin
                    tgt_rate_next = scaled;
                    ms_cnt_next   = '0;
                end
                rdds_pkg::REQ_MS_TICK: begin
                    ms_cnt_next = ms_inc;
                    if (ms_inc > timeout_reg && tgt_rate_reg != '0) begin
                        tgt_rate_next  = '0;
                        out_stale_next = 1'b1;
                    end
                end
                rdds_pkg::REQ_HALT: begin
                    tgt_rate_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pulse_reg <= 1'b0;
            out_stale_reg <= 1'b0;
            cur_rate_reg  <= '0;
            tgt_rate_reg  <= '0;
            phase_reg     <= '0;
            pos_reg       <= '0;
            dir_reg       <= 1'b0;
            ms_cnt_reg    <= '0;
            accel_reg     <= rdds_pkg::ACCEL_RESET;
            max_rate_reg  <= rdds_pkg::MAX_RATE_RESET;
            modulus_reg   <= rdds_pkg::MODULUS_RESET;
            vscale_reg    <= rdds_pkg::VSCALE_RESET;
            timeout_reg   <= rdds_pkg::TIMEOUT_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            out_pulse_reg <= out_pulse_next;
            out_stale_reg <= out_stale_next;
            cur_rate_reg  <= cur_rate_next;
            tgt_rate_reg  <= tgt_rate_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            dir_reg       <= dir_next;
            ms_cnt_reg    <= ms_cnt_next;
            accel_reg     <= accel_next;
            max_rate_reg  <= max_rate_next;
            modulus_reg   <= modulus_next;
            vscale_reg    <= vscale_next;
            timeout_reg   <= timeout_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_req_reg <= in_req_next;
        in_vel_reg <= in_vel_next;
    end

endmodule

@@ hw/rtl/rdds_checker.sv @@
module rdds_checker (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_ready,
    input  logic                                          m_valid,
    input  logic                                          m_ready,
    input  logic                                          m_step_pulse,
    input  logic                                          m_direction,
    input  logic signed [rdds_pkg::POSITION_WIDTH-1:0]    m_position_out,
    input  logic signed [rdds_pkg::RATE_WIDTH-1:0]        m_rate_out,
    input  logic                                          m_stale_halt
);

    // no result straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position_out)
            && $stable(m_rate_out) && $stable(m_step_pulse))
        else $error("stalled result changed");

    // a pulse only comes from a step tick, a stale halt only from a ms tick, so never both
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_step_pulse && m_stale_halt))
        else $error("pulse and stale halt together");

    // direction follows the sign of a nonzero rate
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rate_out != '0 |->
            m_direction == ~m_rate_out[rdds_pkg::RATE_WIDTH-1])
        else $error("direction disagrees with rate sign");

    // back-pressure only while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("request stalled without output stall");

endmodule

bind ramped_dds_step_generator_unit rdds_checker u_checker (.*);

@@ tb/sv/step_gen_checker.sv @@
module step_gen_checker (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    input  logic                                       s_ready,
    input  logic [rdds_pkg::REQ_WIDTH-1:0]             s_req_type,
    input  logic signed [rdds_pkg::VEL_WIDTH-1:0]      s_velocity_cmd,
    input  logic                                       m_valid,
    input  logic                                       m_ready,
    input  logic                                       m_step_pulse,
    input  logic                                       m_direction,
    input  logic signed [rdds_pkg::POSITION_WIDTH-1:0] m_position_out,
    input  logic signed [rdds_pkg::RATE_WIDTH-1:0]     m_rate_out,
    input  logic                                       m_stale_halt,
    input  logic                                       cfg_valid,
    input  logic                                       cfg_ready,
    input  logic [rdds_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
    input  logic [rdds_pkg::CFG_DATA_WIDTH-1:0]        cfg_data,
    output int                                         fail_count,
    output int                                         pending
);

    localparam longint RATE_CAP = (longint'(1) << (rdds_pkg::RATE_WIDTH - 1)) - 1;
    localparam int MS_SATURATE = (1 << rdds_pkg::MS_WIDTH) - 1;

    typedef struct packed {
        logic                                       pulse;
        logic                                       dir;
        logic signed [rdds_pkg::POSITION_WIDTH-1:0] pos;
        logic signed [rdds_pkg::RATE_WIDTH-1:0]     rate;
        logic                                       stale;
    } motion_t;

    motion_t due_motion[$];
    int mismatches = 0;

    longint accel, rate_cap, modulus, vscale, timeout_ms;
    longint cur_rate, tgt_rate, phase;
    logic [rdds_pkg::POSITION_WIDTH-1:0] position;
    logic dir;
    int ms_count;

    function automatic motion_t advance(rdds_pkg::req_type_t req,
                                        logic signed [rdds_pkg::VEL_WIDTH-1:0] vel);
        motion_t r;
        longint wrap, mag, sum, tgt, lim;
        r.pulse = 1'b0;
        r.stale = 1'b0;
        case (req)
            rdds_pkg::REQ_STEP_TICK: begin
                wrap = (modulus == 0) ? 1 : modulus;
                if (cur_rate < tgt_rate) begin
                    cur_rate += accel;
                    if (cur_rate > tgt_rate) cur_rate = tgt_rate;
                end else if (cur_rate > tgt_rate) begin
                    cur_rate -= accel;
                    if (cur_rate < tgt_rate) cur_rate = tgt_rate;
                end
                if (cur_rate != 0) begin
                    dir = (cur_rate > 0);
                    mag = dir ? cur_rate : -cur_rate;
                    sum = phase + mag;
                    if (sum >= wrap) begin
                        sum -= wrap;
                        r.pulse = 1'b1;
                        position = dir ? position + 1'b1 : position - 1'b1;
                    end
                    // excess rate beyond one pulse per tick is lost
                    if (sum >= wrap) sum = wrap - 1;
                    phase = sum;
                end
            end
            rdds_pkg::REQ_VELOCITY: begin
                tgt = (longint'(vel) * vscale) / (longint'(1) << rdds_pkg::VEL_FRAC_BITS);
                lim = (rate_cap > RATE_CAP) ? RATE_CAP : rate_cap;
                if (tgt > lim) tgt = lim;
                if (tgt < -lim) tgt = -lim;
                tgt_rate = tgt;
                ms_count = 0;
            end
            rdds_pkg::REQ_MS_TICK: begin
                if (ms_count < MS_SATURATE) ms_count++;
                if (ms_count > timeout_ms && tgt_rate != 0) begin
                    tgt_rate = 0;
                    r.stale = 1'b1;
                end
            end
            default: tgt_rate = 0;
        endcase
        r.dir = dir;
        r.pos = position;
        r.rate = cur_rate[rdds_pkg::RATE_WIDTH-1:0];
        return r;
    endfunction

    function automatic void match_field(string field, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        motion_t got, want;
        if (!aresetn) begin
            accel = rdds_pkg::ACCEL_RESET;
            rate_cap = rdds_pkg::MAX_RATE_RESET;
            modulus = rdds_pkg::MODULUS_RESET;
            vscale = rdds_pkg::VSCALE_RESET;
            timeout_ms = rdds_pkg::TIMEOUT_RESET;
            cur_rate = 0;
            tgt_rate = 0;
            phase = 0;
            position = '0;
            dir = 1'b0;
            ms_count = 0;
            due_motion.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rdds_pkg::CFG_ACCEL_STEP:
                        accel = cfg_data[rdds_pkg::ACCEL_WIDTH-1:0];
                    rdds_pkg::CFG_MAX_RATE:
                        rate_cap = cfg_data[rdds_pkg::MAX_RATE_WIDTH-1:0];
                    rdds_pkg::CFG_PHASE_MODULUS:
                        modulus = cfg_data[rdds_pkg::PHASE_WIDTH-1:0];
                    rdds_pkg::CFG_VELOCITY_SCALE:
                        vscale = cfg_data[rdds_pkg::VSCALE_WIDTH-1:0];
                    rdds_pkg::CFG_STALE_TIMEOUT:
                        timeout_ms = cfg_data[rdds_pkg::TIMEOUT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                due_motion.push_back(advance(rdds_pkg::req_type_t'(s_req_type),
                                             s_velocity_cmd));
            if (m_valid && m_ready) begin
                got = '{m_step_pulse, m_direction, m_position_out, m_rate_out, m_stale_halt};
                if (due_motion.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    mismatches++;
                end else begin
                    want = due_motion.pop_front();
                    match_field("step_pulse", want.pulse, got.pulse);
                    match_field("direction", want.dir, got.dir);
                    match_field("position_out", want.pos, got.pos);
                    match_field("rate_out", want.rate, got.rate);
                    match_field("stale_halt", want.stale, got.stale);
                end
            end
        end
        fail_count <= mismatches;
        pending <= due_motion.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;

    localparam int HALF_PERIOD    = 6;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_AFTER     = 800;
    localparam int LONG_HOLD      = 64;
    localparam int PHASE_ITEMS    = 115;

    logic                                        aclk = 1'b0;
    logic                                        aresetn = 1'b0;
    logic                                        s_valid = 1'b0;
    logic                                        s_ready;
    logic [rdds_pkg::REQ_WIDTH-1:0]              s_req_type = '0;
    logic signed [rdds_pkg::VEL_WIDTH-1:0]       s_velocity_cmd = '0;
    logic                                        m_valid;
    logic                                        m_ready = 1'b0;
    logic                                        m_step_pulse;
    logic                                        m_direction;
    logic signed [rdds_pkg::POSITION_WIDTH-1:0]  m_position_out;
    logic signed [rdds_pkg::RATE_WIDTH-1:0]      m_rate_out;
    logic                                        m_stale_halt;
    logic                                        cfg_valid = 1'b0;
    logic                                        cfg_ready;
    logic [rdds_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index = '0;
    logic [rdds_pkg::CFG_DATA_WIDTH-1:0]         cfg_data = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int burst_left = 0;
    bit gaps_on = 1'b0;

    always #HALF_PERIOD aclk = ~aclk;

    ramped_dds_step_generator_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_velocity_cmd (s_velocity_cmd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_step_pulse   (m_step_pulse),
        .m_direction    (m_direction),
        .m_position_out (m_position_out),
        .m_rate_out     (m_rate_out),
        .m_stale_halt   (m_stale_halt),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    step_gen_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_velocity_cmd (s_velocity_cmd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_step_pulse   (m_step_pulse),
        .m_direction    (m_direction),
        .m_position_out (m_position_out),
        .m_rate_out     (m_rate_out),
        .m_stale_halt   (m_stale_halt),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(rdds_pkg::cfg_index_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= rdds_pkg::CFG_DATA_WIDTH'(value);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_regs(int accel, int rate_cap, int modulus, int vscale, int timeout_ms);
        settle();
        write_reg(rdds_pkg::CFG_ACCEL_STEP, accel);
        write_reg(rdds_pkg::CFG_MAX_RATE, rate_cap);
        write_reg(rdds_pkg::CFG_PHASE_MODULUS, modulus);
        write_reg(rdds_pkg::CFG_VELOCITY_SCALE, vscale);
        write_reg(rdds_pkg::CFG_STALE_TIMEOUT, timeout_ms);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_req(rdds_pkg::req_type_t req,
                            logic signed [rdds_pkg::VEL_WIDTH-1:0] vel);
        s_valid <= 1'b1;
        s_req_type <= req;
        s_velocity_cmd <= vel;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else if (gaps_on) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic push_random(int count);
        int pick;
        rdds_pkg::req_type_t req;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) req = rdds_pkg::REQ_STEP_TICK;
            else if (pick < 72) req = rdds_pkg::REQ_VELOCITY;
            else if (pick < 95) req = rdds_pkg::REQ_MS_TICK;
            else req = rdds_pkg::REQ_HALT;
            push_req(req, rdds_pkg::VEL_WIDTH'($urandom()));
        end
    endtask

    // receiver: own stall pattern, plus one long hold while the sender keeps offering
    initial begin
        int mode, left, cycles;
        bit held;
        mode = 0;
        left = 0;
        cycles = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (!held && cycles >= HOLD_AFTER && s_valid) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(16, 80);
                end
                left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** ramped_dds_step_generator_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults: zero-rate tick, clamped commands, slow ramp, halt
        push_req(rdds_pkg::REQ_STEP_TICK, '0);
        push_req(rdds_pkg::REQ_VELOCITY, 16'sh7fff);
        push_req(rdds_pkg::REQ_STEP_TICK, '0);
        push_req(rdds_pkg::REQ_STEP_TICK, '1);
        push_req(rdds_pkg::REQ_MS_TICK, '0);
        push_req(rdds_pkg::REQ_HALT, '1);
        push_req(rdds_pkg::REQ_STEP_TICK, '0);
        push_req(rdds_pkg::REQ_VELOCITY, 16'sh8000);

        // modulus zero, full scale, watchdog at zero timeout
        load_regs(65535, 1048575, 0, 1048575, 0);
        push_req(rdds_pkg::REQ_VELOCITY, 16'sh7fff);
        push_req(rdds_pkg::REQ_STEP_TICK, '0);
        push_req(rdds_pkg::REQ_STEP_TICK, '0);
        push_req(rdds_pkg::REQ_MS_TICK, '0);
        push_req(rdds_pkg::REQ_MS_TICK, '0);
        push_req(rdds_pkg::REQ_VELOCITY, 16'sh8000);
        push_req(rdds_pkg::REQ_STEP_TICK, '0);
        push_req(rdds_pkg::REQ_HALT, '0);

        // zero accel holds the rate; watchdog disabled
        load_regs(0, 1048575, 2097151, 1048575, 65535);
        push_req(rdds_pkg::REQ_STEP_TICK, '0);
        push_req(rdds_pkg::REQ_MS_TICK, '0);
        push_req(rdds_pkg::REQ_STEP_TICK, '0);

        // fill the accumulator, then lower the modulus under it
        load_regs(65535, 1048575, 2097151, 1048575, 65535);
        push_req(rdds_pkg::REQ_VELOCITY, 16'sh7fff);
        push_req(rdds_pkg::REQ_STEP_TICK, '0);
        push_req(rdds_pkg::REQ_STEP_TICK, '0);
        load_regs(65535, 1048575, 1000, 1048575, 65535);
        push_req(rdds_pkg::REQ_STEP_TICK, '0);
        push_req(rdds_pkg::REQ_HALT, '0);

        gaps_on = 1'b1;
        load_regs(500, 50000, 100000, 10000, 150);
        push_random(PHASE_ITEMS);

        gaps_on = 1'b0;
        load_regs(65535, 1048575, 2097151, 1048575, 65535);
        push_random(PHASE_ITEMS);

        gaps_on = 1'b1;
        load_regs(0, 0, 1, 0, 0);
        push_random(60);

        for (int k = 0; k < 3; k++) begin
            load_regs($urandom_range(0, 8000), $urandom_range(0, 1048575),
                      $urandom_range(0, 300000), $urandom_range(0, 1048575),
                      $urandom_range(0, 12));
            push_random(PHASE_ITEMS);
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("** ramped_dds_step_generator_unit: PASSED **");
        else
            $display("** ramped_dds_step_generator_unit: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/rdds_pkg.sv
hw/rtl/rdds_scale.sv
hw/rtl/rdds_tick.sv
hw/rtl/ramped_dds_step_generator_unit.sv
hw/rtl/rdds_checker.sv
tb/sv/step_gen_checker.sv
tb/sv/tb_top.sv
